[hdl/wpm_pkg.sv]
package wpm_pkg;

   // Sizing of the search window and of the line
   localparam int PATTERN_MAX = 16;
   localparam int LINE_MAX    = 256;
   localparam int WIN_DEPTH   = PATTERN_MAX + 1;
   localparam int COL_W       = $clog2(LINE_MAX + 1);
   localparam int WIN_IDX_W   = $clog2(WIN_DEPTH);

   // Configuration register indexes
   localparam logic [2:0] REG_PATTERN_LO   = 3'd0;
   localparam logic [2:0] REG_PATTERN_HI   = 3'd1;
   localparam logic [2:0] REG_PATTERN_LEN  = 3'd2;
   localparam logic [2:0] REG_START_ANCHOR = 3'd3;
   localparam logic [2:0] REG_END_ANCHOR   = 3'd4;
   localparam logic [2:0] REG_WHOLE_WORD   = 3'd5;

   // Character codes
   localparam logic [7:0] ANY_CHAR   = 8'h3F;
   localparam logic [7:0] UNDERSCORE = 8'h5F;

   // Compare results of one window cell
   typedef struct packed {
      logic eq_now;   // stored character agrees with its pattern byte
      logic eq_next;  // character being shifted in agrees with its pattern byte
   } cmp_type;

   // One result beat
   typedef struct packed {
      logic       hit_prev;
      logic [7:0] hit_prev_col;
      logic       hit_here;
      logic [7:0] hit_here_col;
      logic       line_matched;
      logic       done_res;
   } res_type;

   function automatic logic is_word(input logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) ||
             (c >= 8'h30 && c <= 8'h39) || (c == UNDERSCORE);
   endfunction

   function automatic logic [7:0] pat_byte(input logic [127:0] pat, input logic [3:0] idx);
      return pat[{idx, 3'b000} +: 8];
   endfunction

endpackage

[hdl/wpm_cell.sv]
module wpm_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               shift_en,
   input  logic               clear,
   input  logic [7:0]         ch_in,
   input  logic [7:0]         pat,
   input  logic               pat_en,
   output logic [7:0]         ch_out,
   output wpm_pkg::cmp_type   cmp
);

   logic [7:0] char_ff;
   logic [7:0] char_in;

   // Take the neighbor's character on a shift, drop it at line end
   always_comb begin
      char_in = char_ff;
      if (clear) begin
         char_in = 8'd0;
      end else if (shift_en) begin
         char_in = ch_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         char_ff <= 8'd0;
      end else begin
         char_ff <= char_in;
      end
   end

   // Compare both the held and the incoming character to this cell's pattern byte
   assign cmp.eq_now  = !pat_en || (pat == wpm_pkg::ANY_CHAR) || (pat == char_ff);
   assign cmp.eq_next = !pat_en || (pat == wpm_pkg::ANY_CHAR) || (pat == ch_in);
   assign ch_out      = char_ff;

endmodule

[hdl/wpm_outq.sv]
module wpm_outq (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  wpm_pkg::res_type   push_data,
   output logic               full,
   output logic               out_valid,
   output wpm_pkg::res_type   out_data,
   input  logic               out_stall
);

   logic             main_valid_ff;
   logic             skid_valid_ff;
   wpm_pkg::res_type main_ff;
   wpm_pkg::res_type skid_ff;
   logic             take;

   assign take = main_valid_ff && !out_stall;

   // Control: refill the output register from the skid stage first
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end
         main_valid_ff <= 1'b1;
      end else if (take) begin
         main_valid_ff <= 1'b0;
      end
   end

   // Payload: hold a stalled beat, park a new one in the skid stage
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !take) begin
            skid_ff <= push_data;
         end else begin
            main_ff <= push_data;
         end
      end
   end

   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

[hdl/wildcard_pattern_line_matcher.sv]
// Streams one text line a character per beat and reports each non-overlapping,
// leftmost-first match of a pattern of up to 16 characters ('?' matches any
// character), with optional start anchor, end anchor and whole-word modes.
// Every input beat yields exactly one result beat: a match is confirmed on the
// beat after its last character (hit_prev), and the line-end beat also carries
// a match ending on the last character (hit_here) and the line summary. The
// block takes one character per clock while req_stall is low; a row of 17
// character cells shifts the window one place per accepted character and
// compares all pattern positions in parallel, and the result is registered
// in the output buffer as the beat is taken. A two-entry output buffer lets
// input continue for one beat while a result is stalled. Characters beyond
// column 255 are ignored. Configuration writes belong between lines.
module wildcard_pattern_line_matcher (
   input  logic         clock,
   input  logic         reset,
   // input channel
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [7:0]   req_ch,
   input  logic         req_line_end,
   // result channel
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic         rsp_hit_prev,
   output logic [7:0]   rsp_hit_prev_col,
   output logic         rsp_hit_here,
   output logic [7:0]   rsp_hit_here_col,
   output logic         rsp_line_matched,
   output logic         rsp_done_res,
   // configuration
   input  logic         csr_write,
   input  logic [2:0]   csr_index,
   input  logic [63:0]  csr_data
);

   localparam int WIN   = wpm_pkg::WIN_DEPTH;
   localparam int PMAX  = wpm_pkg::PATTERN_MAX;
   localparam int COL_W = wpm_pkg::COL_W;

   // Configuration registers
   logic [63:0] pattern_lo_ff;
   logic [63:0] pattern_hi_ff;
   logic [4:0]  pattern_len_ff;
   logic        start_anchor_ff;
   logic        end_anchor_ff;
   logic        whole_word_ff;

   // Line state
   logic [COL_W-1:0] column_ff, column_in;
   logic [COL_W-1:0] next_free_ff, next_free_in;
   logic             any_match_ff, any_match_in;
   logic             anchor_used_ff, anchor_used_in;

   logic                 accept;
   logic                 kept;
   logic                 plen_ok;
   logic [7:0]           win [WIN];
   wpm_pkg::cmp_type     cmp [WIN];
   logic [PMAX-1:0]      eq_now_v;
   logic [PMAX-1:0]      eq_next_v;
   logic                 bnd_now_word;
   logic                 bnd_next_word;
   logic [COL_W-1:0]     plen_c;
   logic [COL_W-1:0]     n_here;
   logic [COL_W-1:0]     nfc_mid;
   logic                 anch_mid;
   logic                 hp;
   logic                 hh;
   logic                 hh_eq;
   logic [COL_W-1:0]     s_prev;
   logic [COL_W-1:0]     s_here;
   wpm_pkg::res_type     res;
   wpm_pkg::res_type     out_res;

   // Window ending at column n-1 passes every positional, mode and character check
   function automatic logic try_ok(
      input logic [COL_W-1:0] n,
      input logic [COL_W-1:0] plen,
      input logic             fsep,
      input logic [COL_W-1:0] nfc,
      input logic             anch,
      input logic             eq_all,
      input logic             bnd_word,
      input logic             sa,
      input logic             ww
   );
      logic [COL_W-1:0] s;
      s = n - plen;
      return (n >= plen) && (s >= nfc) && !anch && !(sa && s != '0) &&
             !(ww && (!fsep || (s != '0 && bnd_word))) && eq_all;
   endfunction

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_lo_ff   <= 64'd0;
         pattern_hi_ff   <= 64'd0;
         pattern_len_ff  <= 5'd0;
         start_anchor_ff <= 1'b0;
         end_anchor_ff   <= 1'b0;
         whole_word_ff   <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            wpm_pkg::REG_PATTERN_LO:   pattern_lo_ff   <= csr_data;
            wpm_pkg::REG_PATTERN_HI:   pattern_hi_ff   <= csr_data;
            wpm_pkg::REG_PATTERN_LEN:  pattern_len_ff  <= csr_data[4:0];
            wpm_pkg::REG_START_ANCHOR: start_anchor_ff <= csr_data[0];
            wpm_pkg::REG_END_ANCHOR:   end_anchor_ff   <= csr_data[0];
            wpm_pkg::REG_WHOLE_WORD:   whole_word_ff   <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign accept  = req_valid && !req_stall;
   assign kept    = column_ff < COL_W'(wpm_pkg::LINE_MAX);
   assign plen_ok = (pattern_len_ff != 5'd0) && (32'(pattern_len_ff) <= PMAX) &&
                    (pattern_len_ff <= 5'd16);
   assign plen_c  = COL_W'(pattern_len_ff);

   // Row of window cells; cell k lines up with pattern byte len-1-k
   for (genvar k = 0; k < WIN; k++) begin : g_cell
      logic [7:0] ch_in;
      logic [4:0] idx;
      logic       pat_en;
      logic [7:0] pat;

      if (k == 0) begin : g_head
         assign ch_in = req_ch;
      end else begin : g_link
         assign ch_in = win[k-1];
      end

      assign pat_en = plen_ok && ({1'b0, pattern_len_ff} > 6'(k));
      assign idx    = pattern_len_ff - 5'(k) - 5'd1;
      assign pat    = wpm_pkg::pat_byte({pattern_hi_ff, pattern_lo_ff}, idx[3:0]);

      wpm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .shift_en (accept && kept),
         .clear    (accept && req_line_end),
         .ch_in    (ch_in),
         .pat      (pat),
         .pat_en   (pat_en),
         .ch_out   (win[k]),
         .cmp      (cmp[k])
      );
   end

   // Gather the per-cell compares
   always_comb begin
      for (int k = 0; k < PMAX; k++) begin
         eq_now_v[k]  = cmp[k].eq_now;
         eq_next_v[k] = cmp[k].eq_next;
      end
   end

   // Character just before the match start, before and after this shift
   always_comb begin
      bnd_now_word  = 1'b0;
      bnd_next_word = 1'b0;
      if (plen_ok) begin
         bnd_now_word = wpm_pkg::is_word(win[pattern_len_ff[wpm_pkg::WIN_IDX_W-1:0]]);
         if (kept) begin
            bnd_next_word =
               wpm_pkg::is_word(win[pattern_len_ff[wpm_pkg::WIN_IDX_W-1:0] - 1'b1]);
         end else begin
            bnd_next_word = bnd_now_word;
         end
      end
   end

   // Match tests: first at the previous character, then at line end
   always_comb begin
      s_prev   = column_ff - plen_c;
      hp       = plen_ok && kept && (column_ff != '0) && !end_anchor_ff &&
                 try_ok(column_ff, plen_c, !wpm_pkg::is_word(req_ch), next_free_ff,
                        anchor_used_ff, &eq_now_v, bnd_now_word,
                        start_anchor_ff, whole_word_ff);
      nfc_mid  = hp ? column_ff : next_free_ff;
      anch_mid = anchor_used_ff || (hp && (start_anchor_ff || end_anchor_ff));
      n_here   = kept ? column_ff + 1'b1 : column_ff;
      s_here   = n_here - plen_c;
      hh_eq    = kept ? &eq_next_v : &eq_now_v;
      hh       = plen_ok && req_line_end &&
                 try_ok(n_here, plen_c, 1'b1, nfc_mid, anch_mid, hh_eq, bnd_next_word,
                        start_anchor_ff, whole_word_ff);
   end

   // Next line state: advance, or return to the start of a line
   always_comb begin
      if (req_line_end) begin
         column_in      = '0;
         next_free_in   = '0;
         any_match_in   = 1'b0;
         anchor_used_in = 1'b0;
      end else begin
         column_in      = n_here;
         next_free_in   = nfc_mid;
         any_match_in   = any_match_ff || hp;
         anchor_used_in = anch_mid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff      <= '0;
         next_free_ff   <= '0;
         any_match_ff   <= 1'b0;
         anchor_used_ff <= 1'b0;
      end else if (accept) begin
         column_ff      <= column_in;
         next_free_ff   <= next_free_in;
         any_match_ff   <= any_match_in;
         anchor_used_ff <= anchor_used_in;
      end
   end

   // Result beat
   always_comb begin
      res.hit_prev     = hp;
      res.hit_prev_col = hp ? 8'(s_prev) : 8'd0;
      res.hit_here     = hh;
      res.hit_here_col = hh ? 8'(s_here) : 8'd0;
      res.line_matched = req_line_end && (any_match_ff || hp || hh);
      res.done_res     = req_line_end;
   end

   wpm_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (res),
      .full      (req_stall),
      .out_valid (rsp_valid),
      .out_data  (out_res),
      .out_stall (rsp_stall)
   );

   assign rsp_hit_prev     = out_res.hit_prev;
   assign rsp_hit_prev_col = out_res.hit_prev_col;
   assign rsp_hit_here     = out_res.hit_here;
   assign rsp_hit_here_col = out_res.hit_here_col;
   assign rsp_line_matched = out_res.line_matched;
   assign rsp_done_res     = out_res.done_res;

endmodule

[hdl/wpm_checker.sv]
module wpm_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_hit_prev,
   input logic [7:0]  rsp_hit_prev_col,
   input logic        rsp_hit_here,
   input logic [7:0]  rsp_hit_here_col,
   input logic        rsp_line_matched,
   input logic        rsp_done_res
);

   // A hit at the last character only shows on the line-end beat
   a_here_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit_here |-> rsp_done_res)
      else $error("hit_here outside line end");

   // The line summary only shows on the line-end beat
   a_matched_at_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_line_matched |-> rsp_done_res)
      else $error("line_matched outside line end");

   // Any hit reported on the line-end beat counts toward the summary
   a_hit_sets_matched: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_done_res && (rsp_hit_prev || rsp_hit_here) |-> rsp_line_matched)
      else $error("line end hit without line_matched");

   // A stalled result beat holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit_prev) &&
      $stable(rsp_hit_prev_col) && $stable(rsp_hit_here) && $stable(rsp_hit_here_col) &&
      $stable(rsp_line_matched) && $stable(rsp_done_res))
      else $error("stalled result beat changed");

endmodule

bind wildcard_pattern_line_matcher wpm_checker u_wpm_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_hit_prev     (rsp_hit_prev),
   .rsp_hit_prev_col (rsp_hit_prev_col),
   .rsp_hit_here     (rsp_hit_here),
   .rsp_hit_here_col (rsp_hit_here_col),
   .rsp_line_matched (rsp_line_matched),
   .rsp_done_res     (rsp_done_res)
);
